/* sv/alid_pkg.sv */
// Package with the operation and status codes and the cell command type of the array list unit.
`default_nettype none

package alid_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W = 2;
   localparam int POS_W = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 8;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OP_W-1:0] OP_READ = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic insert_en;
      logic append_en;
      logic delete_en;
   } cell_cmd_type;

endpackage

`default_nettype wire

/* sv/alid_cell.sv */
// One storage cell of the list: holds a single entry and shifts with its neighbours.
`default_nettype none

module alid_cell
   import alid_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CMP_W = 8
) (
   input  wire logic                       clock,
   input  wire cell_cmd_type               cmd,
   input  wire logic [CMP_W-1:0]           pos,
   input  wire logic [CMP_W-1:0]           count,
   input  wire logic signed [DATA_W-1:0]   item,
   input  wire logic signed [DATA_W-1:0]   left_val,
   input  wire logic signed [DATA_W-1:0]   right_val,
   output logic signed [DATA_W-1:0]        val,
   output logic signed [DATA_W-1:0]        tap
);

   localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

   logic signed [DATA_W-1:0] val_ff;
   logic signed [DATA_W-1:0] val_in;

   always_comb begin
      val_in = val_ff;
      if (cmd.insert_en) begin
         if (IDX > pos) begin
            val_in = left_val;
         end else if (IDX == pos) begin
            val_in = item;
         end
      end else if (cmd.append_en) begin
         if (IDX == count) begin
            val_in = item;
         end
      end else if (cmd.delete_en) begin
         if (IDX >= pos) begin
            val_in = right_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;
   assign tap = (IDX == pos) ? val_ff : '0;

endmodule

`default_nettype wire

/* sv/array_list_insert_delete_unit.sv */
// Top level of the positional array list: request decode, cell row and response register.
//
// Usage: a request transaction on the req_ channel carries an operation, a position and an
// item. Insert and delete move every later entry one place together, since each cell
// of the row loads from its left or right neighbour in parallel. Append writes the cell at
// the current count, read selects the cell at the position.
// Each request gives exactly one response transaction on the rsp_ channel with the removed or
// read item, a status, the count after the request and the empty and full flags.
// rsp_valid rises in the cycle after acceptance. Throughput is one request per cycle while
// no response waits under rsp_stall, as the cell row shifts all its entries in parallel.
// While a response waits under rsp_stall, req_stall is high and no request is taken; the
// request is taken in the same cycle in which the waiting response leaves.
// Reset empties the list at once and drops any pending response; stored entries are not
// cleared, and only entries below the count are ever read.
`default_nettype none

module array_list_insert_delete_unit
   import alid_pkg::*;
#(
   parameter int CAPACITY = 128
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [OP_W-1:0]            req_operation,
   input  wire logic [POS_W-1:0]           req_position,
   input  wire logic signed [DATA_W-1:0]   req_item,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [DATA_W-1:0]        rsp_data,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic [COUNT_W-1:0]              rsp_count,
   output logic                            rsp_is_empty_flag,
   output logic                            rsp_is_full_flag
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CMP_W-1:0] CAP = CMP_W'(CAPACITY);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic rsp_empty_ff;
   logic rsp_full_ff;

   logic accept;
   logic [CMP_W-1:0] pos_w;
   logic [CMP_W-1:0] cnt_w;
   logic [CMP_W-1:0] cnt_next_w;
   logic is_full;
   logic [STATUS_W-1:0] status;
   logic signed [DATA_W-1:0] rd_data;
   logic signed [DATA_W-1:0] out_data;
   cell_cmd_type cmd;

   logic signed [DATA_W-1:0] vals [CAPACITY];
   logic signed [DATA_W-1:0] taps [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;
   assign pos_w = CMP_W'(req_position);
   assign cnt_w = CMP_W'(count_ff);
   assign is_full = (cnt_w == CAP);

   always_comb begin
      status = ST_OK;
      unique case (req_operation)
         OP_INSERT: begin
            if (is_full) begin
               status = ST_FULL;
            end else if (pos_w > cnt_w) begin
               status = ST_BAD_POS;
            end
         end
         OP_APPEND: begin
            if (is_full) begin
               status = ST_FULL;
            end
         end
         OP_DELETE, OP_READ: begin
            if (pos_w >= cnt_w) begin
               status = ST_BAD_POS;
            end
         end
         default: status = ST_OK;
      endcase
   end

   always_comb begin
      cmd.insert_en = accept && (req_operation == OP_INSERT) && (status == ST_OK);
      cmd.append_en = accept && (req_operation == OP_APPEND) && (status == ST_OK);
      cmd.delete_en = accept && (req_operation == OP_DELETE) && (status == ST_OK);
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [DATA_W-1:0] left_val;
         logic signed [DATA_W-1:0] right_val;
         if (gi == 0) begin : g_first
            assign left_val = '0;
         end else begin : g_mid_l
            assign left_val = vals[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_val = '0;
         end else begin : g_mid_r
            assign right_val = vals[gi+1];
         end
         alid_cell #(
            .INDEX(gi),
            .CMP_W(CMP_W)
         ) u_cell (
            .clock(clock),
            .cmd(cmd),
            .pos(pos_w),
            .count(cnt_w),
            .item(req_item),
            .left_val(left_val),
            .right_val(right_val),
            .val(vals[gi]),
            .tap(taps[gi])
         );
      end
   endgenerate

   always_comb begin
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_data = rd_data | taps[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert_en || cmd.append_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.delete_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign cnt_next_w = CMP_W'(count_in);
   assign out_data = ((status == ST_OK) &&
                      ((req_operation == OP_DELETE) || (req_operation == OP_READ)))
                     ? rd_data : '0;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= out_data;
         rsp_status_ff <= status;
         rsp_count_ff <= cnt_next_w[COUNT_W-1:0];
         rsp_empty_ff <= (count_in == '0);
         rsp_full_ff <= (cnt_next_w == CAP);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_is_empty_flag = rsp_empty_ff;
   assign rsp_is_full_flag = rsp_full_ff;

endmodule

`default_nettype wire

/* sv/alid_checker.sv */
// Port-level checker for the array list unit and its bind to the top level.
`default_nettype none

module alid_checker
   import alid_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic signed [DATA_W-1:0]   rsp_data,
   input wire logic [STATUS_W-1:0]        rsp_status,
   input wire logic [COUNT_W-1:0]         rsp_count,
   input wire logic                       rsp_is_empty_flag,
   input wire logic                       rsp_is_full_flag
);

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request gave no response");

   a_error_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_data == '0))
      else $error("error response carries data");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty_flag) |-> (rsp_count == '0))
      else $error("empty flag with non-zero count");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_empty_flag && rsp_is_full_flag))
      else $error("empty and full flags together");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data) && $stable(rsp_count)))
      else $error("stalled response changed");

endmodule

bind array_list_insert_delete_unit alid_checker u_alid_checker (.*);

`default_nettype wire

/* tb/array_list_insert_delete_unit_tb.sv */
// Self-checking testbench for the positional array list unit: directed edge cases, then random traffic.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import alid_pkg::*;

   localparam int LIST_DEPTH = 128;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       count;
      logic                     empty_flag;
      logic                     full_flag;
   } list_response_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [OP_W-1:0]            req_operation = OP_READ;
   logic [POS_W-1:0]           req_position = '0;
   logic signed [DATA_W-1:0]   req_item = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]   rsp_data;
   logic [STATUS_W-1:0]        rsp_status;
   logic [COUNT_W-1:0]         rsp_count;
   logic                       rsp_is_empty_flag;
   logic                       rsp_is_full_flag;

   logic signed [DATA_W-1:0]   list_model [LIST_DEPTH];
   int                         list_fill = 0;
   list_response_type          expected_responses [$];
   int                         mismatch_count = 0;
   int                         idle_cycles = 0;
   bit                         steady = 1'b0;

   array_list_insert_delete_unit #(.CAPACITY(LIST_DEPTH)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_position      (req_position),
      .req_item          (req_item),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data),
      .rsp_status        (rsp_status),
      .rsp_count         (rsp_count),
      .rsp_is_empty_flag (rsp_is_empty_flag),
      .rsp_is_full_flag  (rsp_is_full_flag)
   );

   always #1 clock = ~clock;

   function automatic list_response_type apply_list_request(input logic [OP_W-1:0] op,
                                                            input logic [POS_W-1:0] pos,
                                                            input logic signed [DATA_W-1:0] item);
      list_response_type r;
      int p;
      int i;
      p = int'(pos);
      r.data = '0;
      r.status = ST_OK;
      case (op)
         OP_INSERT: begin
            if (list_fill >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else if (p > list_fill) begin
               r.status = ST_BAD_POS;
            end else begin
               for (i = list_fill; i > p; i--) list_model[i] = list_model[i-1];
               list_model[p] = item;
               list_fill++;
            end
         end
         OP_APPEND: begin
            if (list_fill >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               list_model[list_fill] = item;
               list_fill++;
            end
         end
         OP_DELETE: begin
            if (p >= list_fill) begin
               r.status = ST_BAD_POS;
            end else begin
               r.data = list_model[p];
               for (i = p; i + 1 < list_fill; i++) list_model[i] = list_model[i+1];
               list_fill--;
            end
         end
         default: begin
            if (p >= list_fill) r.status = ST_BAD_POS;
            else r.data = list_model[p];
         end
      endcase
      r.count = COUNT_W'(list_fill);
      r.empty_flag = (list_fill == 0);
      r.full_flag = (list_fill == LIST_DEPTH);
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] random_item();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -32'sd1;
         4, 5: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
         default: return $signed($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] item);
      bit stalled;
      while (!steady && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_position <= pos;
      req_item <= item;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      expected_responses.push_back(apply_list_request(op, pos, item));
   endtask

   task automatic test_empty_list_errors();
      send_request(OP_READ, 8'd0, random_item());
      send_request(OP_DELETE, 8'd0, random_item());
      send_request(OP_INSERT, 8'd1, random_item());
      send_request(OP_INSERT, 8'd255, 32'sh7fff_ffff);
      send_request(OP_READ, 8'd128, random_item());
   endtask

   task automatic test_positional_edits();
      send_request(OP_INSERT, 8'd0, 32'sh8000_0000);
      send_request(OP_APPEND, 8'd255, 32'sh7fff_ffff);
      send_request(OP_INSERT, 8'd1, -32'sd1);
      send_request(OP_INSERT, 8'd3, 32'sd0);
      send_request(OP_INSERT, 8'd5, 32'sd7);
      send_request(OP_INSERT, 8'd0, 32'sh5555_5555);
      send_request(OP_INSERT, 8'd2, 32'shaaaa_aaaa);
      for (int i = 0; i <= 6; i++) send_request(OP_READ, POS_W'(i), random_item());
      send_request(OP_READ, 8'd255, random_item());
      send_request(OP_DELETE, 8'd2, random_item());
      send_request(OP_DELETE, POS_W'(list_fill - 1), random_item());
      send_request(OP_DELETE, 8'd0, random_item());
      send_request(OP_DELETE, POS_W'(list_fill), random_item());
      send_request(OP_DELETE, 8'd200, random_item());
      send_request(OP_READ, 8'd0, random_item());
   endtask

   task automatic test_full_list();
      while (list_fill < LIST_DEPTH) begin
         if ($urandom_range(0, 1)) send_request(OP_APPEND, POS_W'($urandom), random_item());
         else send_request(OP_INSERT, POS_W'($urandom_range(0, list_fill)), random_item());
      end
      send_request(OP_APPEND, 8'd0, random_item());
      send_request(OP_INSERT, 8'd0, random_item());
      send_request(OP_INSERT, 8'd200, random_item());
      send_request(OP_INSERT, 8'd128, random_item());
      send_request(OP_READ, 8'd127, random_item());
      send_request(OP_READ, 8'd128, random_item());
      send_request(OP_DELETE, 8'd127, random_item());
      send_request(OP_INSERT, 8'd127, random_item());
      send_request(OP_DELETE, 8'd0, random_item());
      send_request(OP_APPEND, 8'd0, random_item());
      send_request(OP_APPEND, 8'd0, random_item());
      while (list_fill > 0) send_request(OP_DELETE, POS_W'($urandom_range(0, list_fill - 1)),
                                         random_item());
      send_request(OP_DELETE, 8'd0, random_item());
      send_request(OP_APPEND, 8'd0, random_item());
   endtask

   task automatic test_random_traffic(input int n_items);
      bit growing;
      int roll;
      logic [OP_W-1:0] op;
      logic [POS_W-1:0] pos;
      growing = 1'b1;
      repeat (n_items) begin
         if (list_fill == LIST_DEPTH) growing = 1'b0;
         else if (list_fill == 0) growing = 1'b1;
         else if ($urandom_range(0, 99) == 0) growing = !growing;
         roll = $urandom_range(0, 99);
         if (growing) begin
            op = (roll < 40) ? OP_INSERT : (roll < 70) ? OP_APPEND : (roll < 85) ? OP_DELETE
                 : OP_READ;
         end else begin
            op = (roll < 15) ? OP_INSERT : (roll < 25) ? OP_APPEND : (roll < 75) ? OP_DELETE
                 : OP_READ;
         end
         roll = $urandom_range(0, 99);
         if (roll < 6) pos = POS_W'($urandom_range(0, 255));
         else if (roll < 14) pos = POS_W'(list_fill + $urandom_range(0, 2));
         else if (op == OP_INSERT || op == OP_APPEND) pos = POS_W'($urandom_range(0, list_fill));
         else if (list_fill == 0) pos = '0;
         else pos = POS_W'($urandom_range(0, list_fill - 1));
         send_request(op, pos, random_item());
      end
   endtask

   task automatic test_steady_burst();
      steady = 1'b1;
      test_random_traffic(150);
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 21);
   end

   always @(posedge clock) begin : check_responses
      list_response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("response transaction with no request outstanding");
         end else begin
            want = expected_responses.pop_front();
            if (rsp_data !== want.data)
               report_mismatch($sformatf("data: expected %h, got %h", want.data, rsp_data));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status: expected %0d, got %0d", want.status,
                                         rsp_status));
            if (rsp_count !== want.count)
               report_mismatch($sformatf("count: expected %0d, got %0d", want.count, rsp_count));
            if (rsp_is_empty_flag !== want.empty_flag)
               report_mismatch($sformatf("empty flag: expected %b, got %b", want.empty_flag,
                                         rsp_is_empty_flag));
            if (rsp_is_full_flag !== want.full_flag)
               report_mismatch($sformatf("full flag: expected %b, got %b", want.full_flag,
                                         rsp_is_full_flag));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("array_list_insert_delete_unit test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list_errors();
      test_positional_edits();
      test_full_list();
      test_random_traffic(200);
      test_steady_burst();
      test_random_traffic(250);
      req_valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("array_list_insert_delete_unit test passed");
      end else begin
         $display("array_list_insert_delete_unit test failed");
      end
      $finish;
   end

endmodule

/* array_list_insert_delete_unit.f */
sv/alid_pkg.sv
sv/alid_cell.sv
sv/array_list_insert_delete_unit.sv
sv/alid_checker.sv
tb/array_list_insert_delete_unit_tb.sv
